[src/backlight_auto_dim_fader_macros.svh]
// Assertion macros used by the one asserting file of the backlight fader.
// BLADF_ASSERT is quiet while reset is held; BLADF_ASSERT_RST checks in reset too.
`ifndef BACKLIGHT_AUTO_DIM_FADER_MACROS_SVH
`define BACKLIGHT_AUTO_DIM_FADER_MACROS_SVH
`ifndef SYNTHESIS
`define BLADF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BLADF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLADF_ASSERT(lbl, prop, msg)
`define BLADF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[src/bladf_pkg.sv]
`timescale 1ns / 1ps
package bladf_pkg;

  // Item and port widths
  localparam int ACTION_W   = 2;
  localparam int ELAPSED_W  = 16;
  localparam int LEVEL_W    = 8;
  localparam int IN_TDATA_W = 24;   // elapsed_ms, level
  localparam int OUT_TDATA_W = 8;   // duty
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // State widths
  localparam int ACT_W  = 26;
  localparam int FADE_W = 16;
  localparam int TMO_S_W  = 16;
  localparam int TMO_MS_W = 24;

  // Fade step arithmetic
  localparam int MAX_STEP_MS = 50;
  localparam int MS_PER_S    = 1000;
  localparam int DT_W        = $clog2(MAX_STEP_MS + 1);
  // mag * dt * 8 fits in this many bits
  localparam int PROD_W      = FADE_W + DT_W + 3;
  // Exact floor division by 1000 through a rounded-up reciprocal
  localparam int RECIP_SHIFT = PROD_W + $clog2(MS_PER_S);
  localparam longint RECIP_M = ((64'd1 << RECIP_SHIFT) + MS_PER_S - 1) / MS_PER_S;
  localparam int RECIP_W     = $clog2(RECIP_M + 1);
  localparam int MUL_W       = (PROD_W > RECIP_W) ? PROD_W : RECIP_W;
  localparam int MULP_W      = 2 * MUL_W;
  // A quotient of PROD_W bits by 1000 needs at most PROD_W - 9 bits
  localparam int STEP_W      = PROD_W - 9;
  localparam int SUM_W       = STEP_W + 1;
  localparam logic [FADE_W-1:0] SNAP_LIM = 16'd128;

  // Reset values
  localparam logic [LEVEL_W-1:0]  LOW_RST  = 8'd10;
  localparam logic [TMO_S_W-1:0]  TMO_S_RST = 16'd60;
  localparam logic [TMO_MS_W-1:0] TMO_MS_RST = 24'd30000;
  localparam logic [LEVEL_W-1:0]  FULL_RST = 8'd255;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WAKE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SET    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO_S   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 3'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0]  low_brightness;
    logic [TMO_S_W-1:0]  dim_timeout_s;
    logic [TMO_MS_W-1:0] initial_timeout_ms;
    logic [LEVEL_W-1:0]  full_brightness;
  } cfg_t;

  typedef struct packed {
    logic               wr;
    logic [LEVEL_W-1:0] val;
  } low_upd_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               ready;
    logic               done;
    logic [LEVEL_W-1:0] duty;
    logic               dimmed;
  } seq_stat_t;

endpackage

[src/backlight_auto_dim_fader.sv]
`timescale 1ns / 1ps
// An update item steps through S_TMO, S_CHK, S_SCL and S_STP to S_DONE (S_TMO and S_CHK
// alone when the level is already at or within half a count of its target); wake and set
// items go straight to S_DONE, which waits for the output register to be free. Three
// passes through the one shared multiplier (timeout scale, fade step, divide by 1000)
// serve an update item with a fade step; one item in flight, none taken before S_IDLE.
// Reset (rst_n low, synchronous): control and config registers to defaults, level at full.
`include "backlight_auto_dim_fader_macros.svh"
module backlight_auto_dim_fader (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bladf_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] elapsed_ms, [23:16] level
  input  logic [bladf_pkg::ACTION_W-1:0]      in_tuser,   // [1:0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bladf_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] duty
  output logic                                out_tuser,  // [0] dimmed
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bladf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bladf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bladf_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  low_upd_t            low_upd;
  mul_req_t            mul_req;
  logic [MULP_W-1:0]   mul_p;
  seq_stat_t           seq_stat;
  logic                in_acc;
  logic                cfg_wr;
  logic                out_free;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_duty_r;
  logic                out_dim_r;

  assign in_tready = seq_stat.ready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;

  // Decode register writes; indexes beyond the list are dropped
  always_comb begin
    cfg_nxt     = cfg_r;
    low_upd.wr  = 1'b0;
    low_upd.val = cfg_data[LEVEL_W-1:0];
    if (cfg_wr) begin
      case (cfg_index)
        CFG_LOW: begin
          cfg_nxt.low_brightness = cfg_data[LEVEL_W-1:0];
          low_upd.wr             = 1'b1;
        end
        CFG_TMO_S:  cfg_nxt.dim_timeout_s      = cfg_data[TMO_S_W-1:0];
        CFG_TMO_MS: cfg_nxt.initial_timeout_ms = cfg_data[TMO_MS_W-1:0];
        CFG_FULL:   cfg_nxt.full_brightness    = cfg_data[LEVEL_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_brightness     <= LOW_RST;
      cfg_r.dim_timeout_s      <= TMO_S_RST;
      cfg_r.initial_timeout_ms <= TMO_MS_RST;
      cfg_r.full_brightness    <= FULL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bladf_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .p_r (mul_p)
  );

  bladf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_action  (in_tuser),
    .in_elapsed (in_tdata[ELAPSED_W-1:0]),
    .in_level   (in_tdata[ELAPSED_W +: LEVEL_W]),
    .cfg        (cfg_r),
    .low_upd    (low_upd),
    .out_free   (out_free),
    .mul_req    (mul_req),
    .mul_p      (mul_p),
    .stat       (seq_stat)
  );

  // Output register: hold the item until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_stat.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_stat.done) begin
      out_duty_r <= seq_stat.duty;
      out_dim_r  <= seq_stat.dimmed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_duty_r;
  assign out_tuser  = out_dim_r;

  `BLADF_ASSERT(a_busy_after_accept, in_acc |=> !in_tready, "block ready right after accepting an item")
  `BLADF_ASSERT(a_out_from_done, $rose(out_tvalid) |-> $past(seq_stat.done), "result raised without a finished item")
  `BLADF_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_tvalid && in_tready), "block not idle after reset")

endmodule

[src/bladf_mul.sv]
`timescale 1ns / 1ps
module bladf_mul (
  input  logic                        clk,
  input  bladf_pkg::mul_req_t         req,
  output logic [bladf_pkg::MULP_W-1:0] p_r
);
  import bladf_pkg::*;

  // Multiply and register the product for the next sequencer step
  always_ff @(posedge clk) begin
    p_r <= MULP_W'(req.a) * MULP_W'(req.b);
  end

endmodule

[src/bladf_seq.sv]
`timescale 1ns / 1ps
module bladf_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  logic [bladf_pkg::ACTION_W-1:0]  in_action,
  input  logic [bladf_pkg::ELAPSED_W-1:0] in_elapsed,
  input  logic [bladf_pkg::LEVEL_W-1:0]   in_level,
  input  bladf_pkg::cfg_t               cfg,
  input  bladf_pkg::low_upd_t           low_upd,
  input  logic                          out_free,
  output bladf_pkg::mul_req_t           mul_req,
  input  logic [bladf_pkg::MULP_W-1:0]  mul_p,
  output bladf_pkg::seq_stat_t          stat
);
  import bladf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TMO  = 6'b000010,
    S_CHK  = 6'b000100,
    S_SCL  = 6'b001000,
    S_STP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ACT_W-1:0]     act_r, act_nxt;
  logic                 dim_r, dim_nxt;
  logic                 user_r, user_nxt;
  logic [FADE_W-1:0]    fade_r, fade_nxt;
  logic [LEVEL_W-1:0]   tgt_r, tgt_nxt;
  logic                 dir_r, dir_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;

  logic [ACT_W:0]       act_sum;
  logic [ACT_W-1:0]     tmo;
  logic [LEVEL_W-1:0]   tgt_eff;
  logic [FADE_W-1:0]    tgt16;
  logic                 up;
  logic [FADE_W-1:0]    mag;
  logic [DT_W-1:0]      dt;
  logic [PROD_W-4:0]    prod_md;
  logic [PROD_W-1:0]    scaled;
  logic [STEP_W-1:0]    step;
  logic [SUM_W-1:0]     sum_up;

  // Shared datapath terms
  always_comb begin
    act_sum = {1'b0, act_r} + (ACT_W + 1)'(elapsed_r);
    tmo     = user_r ? mul_p[ACT_W-1:0] : ACT_W'(cfg.initial_timeout_ms);
    tgt_eff = tgt_r;
    if (!dim_r && (act_r >= tmo)) begin
      tgt_eff = cfg.low_brightness;
    end
    tgt16   = {tgt_eff, 8'h00};
    up      = tgt16 > fade_r;
    mag     = up ? (tgt16 - fade_r) : (fade_r - tgt16);
    dt      = (elapsed_r > ELAPSED_W'(MAX_STEP_MS)) ? DT_W'(MAX_STEP_MS) : DT_W'(elapsed_r);
    prod_md = mul_p[PROD_W-4:0];
    scaled  = dir_r ? (PROD_W'(prod_md) << 3) : (PROD_W'(prod_md) << 2);
    step    = mul_p[RECIP_SHIFT +: STEP_W];
    sum_up  = SUM_W'(fade_r) + SUM_W'(step);
  end

  // Sequencer: one pass per item, three multiplier trips per fade-step update
  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    dim_nxt     = dim_r;
    user_nxt    = user_r;
    fade_nxt    = fade_r;
    tgt_nxt     = tgt_r;
    dir_nxt     = dir_r;
    elapsed_nxt = elapsed_r;
    mul_req     = '0;

    // Low level written while dimmed retargets at once, outside S_CHK
    if (low_upd.wr && dim_r) begin
      tgt_nxt = low_upd.val;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          elapsed_nxt = in_elapsed;
          state_nxt   = S_DONE;
          case (in_action)
            ACT_UPDATE: begin
              state_nxt = S_TMO;
            end
            ACT_WAKE: begin
              act_nxt = '0;
              if (dim_r) begin
                dim_nxt  = 1'b0;
                user_nxt = 1'b1;
              end
              tgt_nxt = cfg.full_brightness;
            end
            ACT_SET: begin
              tgt_nxt  = in_level;
              fade_nxt = {in_level, 8'h00};
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TMO: begin
        // Advance the saturating counter and form the user timeout
        act_nxt   = act_sum[ACT_W] ? '1 : act_sum[ACT_W-1:0];
        mul_req.a = MUL_W'(cfg.dim_timeout_s);
        mul_req.b = MUL_W'(MS_PER_S);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!dim_r && (act_r >= tmo)) begin
          dim_nxt = 1'b1;
        end
        tgt_nxt = tgt_eff;
        if (tgt16 == fade_r) begin
          state_nxt = S_DONE;
        end else if (mag < SNAP_LIM) begin
          fade_nxt  = tgt16;
          state_nxt = S_DONE;
        end else begin
          mul_req.a = MUL_W'(mag);
          mul_req.b = MUL_W'(dt);
          dir_nxt   = up;
          state_nxt = S_SCL;
        end
      end
      S_SCL: begin
        // Apply speed, then divide by 1000 through the reciprocal
        mul_req.a = MUL_W'(scaled);
        mul_req.b = MUL_W'(RECIP_M);
        state_nxt = S_STP;
      end
      S_STP: begin
        if (dir_r) begin
          fade_nxt = (sum_up > SUM_W'(16'hFFFF)) ? 16'hFFFF : sum_up[FADE_W-1:0];
        end else begin
          fade_nxt = (SUM_W'(step) > SUM_W'(fade_r)) ? '0 :
                     FADE_W'(SUM_W'(fade_r) - SUM_W'(step));
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Status towards the ports
  always_comb begin
    stat.ready  = (state_r == S_IDLE);
    stat.done   = (state_r == S_DONE) && out_free;
    stat.duty   = fade_r[FADE_W-1:8];
    stat.dimmed = dim_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      dim_r   <= 1'b0;
      user_r  <= 1'b0;
      fade_r  <= {FULL_RST, 8'h00};
      tgt_r   <= FULL_RST;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      dim_r   <= dim_nxt;
      user_r  <= user_nxt;
      fade_r  <= fade_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  // Hold item payload and direction
  always_ff @(posedge clk) begin
    dir_r     <= dir_nxt;
    elapsed_r <= elapsed_nxt;
  end

endmodule

[tb/sv/backlight_fader_checker.sv]
`timescale 1ns / 1ps
// Watches the item, result and register channels of the backlight fader,
// keeps its own copy of the fade state and compares every result item.
module backlight_fader_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [bladf_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] elapsed_ms, [23:16] level
  input  logic [bladf_pkg::ACTION_W-1:0]    in_tuser,   // [1:0] action
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [bladf_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] duty
  input  logic                              out_tuser,  // [0] dimmed
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bladf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bladf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);
  import bladf_pkg::*;

  localparam logic [ACT_W-1:0] ACTIVITY_CEIL = '1;
  localparam longint HALF_STEP = 128;
  localparam longint RISE_RATE = 8;
  localparam longint FALL_RATE = 4;
  localparam longint FADE_CEIL = 65535;

  typedef struct packed {
    logic [LEVEL_W-1:0] duty;
    logic               dimmed;
  } duty_report_t;

  duty_report_t expected_duty_q[$];

  // Register copy
  logic [LEVEL_W-1:0]  low_lvl;
  logic [TMO_S_W-1:0]  tmo_s;
  logic [TMO_MS_W-1:0] tmo_ms;
  logic [LEVEL_W-1:0]  full_lvl;

  // Fader state
  logic [ACT_W-1:0]   activity;
  logic               dim_now;
  logic               user_tmo;
  logic [FADE_W-1:0]  fade;
  logic [LEVEL_W-1:0] target;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void restore_defaults();
    low_lvl  = LOW_RST;
    tmo_s    = TMO_S_RST;
    tmo_ms   = TMO_MS_RST;
    full_lvl = FULL_RST;
    activity = '0;
    dim_now  = 1'b0;
    user_tmo = 1'b0;
    fade     = {FULL_RST, 8'h00};
    target   = FULL_RST;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_LOW: begin
        low_lvl = val[LEVEL_W-1:0];
        // while dimmed the target tracks the low level straight away
        if (dim_now) target = low_lvl;
      end
      CFG_TMO_S:  tmo_s    = val[TMO_S_W-1:0];
      CFG_TMO_MS: tmo_ms   = val[TMO_MS_W-1:0];
      CFG_FULL:   full_lvl = val[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // First-order step toward the target in 8.8, truncated toward zero
  function automatic void fade_toward_target(input logic [ELAPSED_W-1:0] elapsed);
    longint goal, now_lvl, gap, mag, step, dt;
    goal    = longint'(target) * 256;
    now_lvl = longint'(fade);
    if (now_lvl == goal) return;
    dt  = (elapsed > MAX_STEP_MS) ? longint'(MAX_STEP_MS) : longint'(elapsed);
    gap = goal - now_lvl;
    mag = (gap < 0) ? -gap : gap;
    // within half a count: snap onto the target
    if (mag < HALF_STEP) begin
      fade = goal[FADE_W-1:0];
      return;
    end
    step    = mag * ((gap > 0) ? RISE_RATE : FALL_RATE) * dt / longint'(MS_PER_S);
    now_lvl = (gap > 0) ? now_lvl + step : now_lvl - step;
    if (now_lvl < 0) now_lvl = 0;
    if (now_lvl > FADE_CEIL) now_lvl = FADE_CEIL;
    fade = now_lvl[FADE_W-1:0];
  endfunction

  function automatic duty_report_t advance_backlight(input logic [ACTION_W-1:0]  action,
                                                     input logic [ELAPSED_W-1:0] elapsed,
                                                     input logic [LEVEL_W-1:0]   lvl);
    logic [31:0]      limit;
    logic [ACT_W+1:0] tally;
    duty_report_t     r;
    case (action)
      ACT_UPDATE: begin
        limit = user_tmo ? 32'(tmo_s) * 32'(MS_PER_S) : 32'(tmo_ms);
        // saturate the inactivity counter rather than wrap
        tally    = (ACT_W+2)'(activity) + (ACT_W+2)'(elapsed);
        activity = (tally > (ACT_W+2)'(ACTIVITY_CEIL)) ? ACTIVITY_CEIL : tally[ACT_W-1:0];
        if (!dim_now && 32'(activity) >= limit) begin
          dim_now = 1'b1;
          target  = low_lvl;
        end
        fade_toward_target(elapsed);
      end
      ACT_WAKE: begin
        activity = '0;
        if (dim_now) begin
          dim_now  = 1'b0;
          user_tmo = 1'b1;
        end
        target = full_lvl;
      end
      ACT_SET: begin
        target = lvl;
        fade   = {lvl, 8'h00};
      end
      default: ;
    endcase
    r.duty   = fade[FADE_W-1:8];
    r.dimmed = dim_now;
    return r;
  endfunction

  // Compare results first, then take register writes and new items
  always @(posedge clk) begin
    duty_report_t want;
    if (!rst_n) begin
      restore_defaults();
      expected_duty_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_duty_q.size() == 0) begin
          report_mismatch($sformatf("result item with none expected: duty %0d dimmed %0b",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_duty_q.pop_front();
          checked++;
          if (out_tdata !== want.duty)
            report_mismatch($sformatf("duty %0d, expected %0d", out_tdata, want.duty));
          if (out_tuser !== want.dimmed)
            report_mismatch($sformatf("dimmed %b, expected %b", out_tuser, want.dimmed));
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        expected_duty_q.push_back(advance_backlight(in_tuser, in_tdata[ELAPSED_W-1:0],
                                                    in_tdata[ELAPSED_W +: LEVEL_W]));
    end
    pending = expected_duty_q.size();
  end

endmodule

[tb/sv/backlight_auto_dim_fader_tb.sv]
`timescale 1ns / 1ps
module backlight_auto_dim_fader_tb;
  import bladf_pkg::*;

  localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;
  localparam int PHASES       = 8;
  localparam int OVERFLOW_RUN = 1030;
  localparam int DRAIN_LIMIT  = 4000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [ACTION_W-1:0]    in_tuser   = '0;
  logic                   out_tready = 1'b1;
  logic                   cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_ready;

  int fail_count, pending, checked;
  bit calm = 1'b0;
  int stall_left = 0;
  int n_update = 0, n_wake = 0, n_set = 0, n_unused = 0, n_cfg = 0, n_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  backlight_auto_dim_fader DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  backlight_fader_checker fader_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Stall the result side in bursts, none started once the run has gone calm
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  task automatic send_item(input logic [ACTION_W-1:0]  action,
                           input logic [ELAPSED_W-1:0] elapsed,
                           input logic [LEVEL_W-1:0]   lvl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = action;
    in_tdata  = {lvl, elapsed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    case (action)
      ACT_UPDATE: n_update++;
      ACT_WAKE:   n_wake++;
      ACT_SET:    n_set++;
      default:    n_unused++;
    endcase
  endtask

  // Write only once every result item has come back; spare upper bits carry noise
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    while (pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    case (idx)
      CFG_LOW, CFG_FULL: cfg_data = {noise[CFG_DATA_W-1:LEVEL_W], val[LEVEL_W-1:0]};
      CFG_TMO_S:         cfg_data = {noise[CFG_DATA_W-1:TMO_S_W], val[TMO_S_W-1:0]};
      default:           cfg_data = val;
    endcase
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_cfg++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_DATA_W-1:0] ceil,
                                                         input int usual_hi);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ceil;
      default: return CFG_DATA_W'($urandom_range(0, usual_hi));
    endcase
  endfunction

  // Mostly fade-sized ticks, with zero, capped and huge ones mixed in
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ELAPSED_W'($urandom);
      2:       return '1;
      3:       return ELAPSED_W'($urandom_range(MAX_STEP_MS - 5, MAX_STEP_MS + 5));
      default: return ELAPSED_W'($urandom_range(1, 60));
    endcase
  endfunction

  task automatic run_phase(input int n_items);
    int wake_pct;
    int r;
    write_reg(CFG_LOW, pick_setting(24'hFF, 255));
    write_reg(CFG_TMO_S, pick_setting(24'hFFFF, 2));
    write_reg(CFG_TMO_MS, pick_setting(24'hFFFFFF, 3000));
    write_reg(CFG_FULL, pick_setting(24'hFF, 255));
    // rare wakes let the counter reach the timeout and the fade settle
    wake_pct = $urandom_range(1, 10);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < wake_pct)
        send_item(ACT_WAKE, ELAPSED_W'($urandom), LEVEL_W'($urandom));
      else if (r < wake_pct + 8)
        send_item(ACT_SET, ELAPSED_W'($urandom), LEVEL_W'($urandom));
      else if (r < wake_pct + 13)
        send_item(ACT_UNUSED, ELAPSED_W'($urandom), LEVEL_W'($urandom));
      else
        send_item(ACT_UPDATE, pick_elapsed(), LEVEL_W'($urandom));
    end
    n_phase++;
  endtask

  initial begin
    int waited;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults, field extremes and the unused action code
    send_item(ACT_UPDATE, 16'd0, 8'd0);
    send_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
    send_item(ACT_SET, 16'hFFFF, 8'd0);
    send_item(ACT_SET, 16'd0, 8'hFF);
    send_item(ACT_UPDATE, 16'd29998, 8'hAA);
    // initial timeout hit exactly on the boundary
    write_reg(CFG_TMO_MS, 24'd29999);
    send_item(ACT_UPDATE, 16'd0, 8'h55);
    send_item(ACT_UPDATE, 16'd1, 8'd0);
    send_item(ACT_UPDATE, 16'd50, 8'd0);
    send_item(ACT_UPDATE, 16'd51, 8'd0);
    // raise the low level while dimmed: fade up toward it
    write_reg(CFG_LOW, 24'd200);
    send_item(ACT_UPDATE, 16'd50, 8'd0);
    send_item(ACT_UPDATE, 16'd50, 8'd0);
    send_item(ACT_WAKE, 16'hFFFF, 8'hFF);
    send_item(ACT_UPDATE, 16'd50, 8'd0);
    // full level change takes effect only at the next wake
    write_reg(CFG_FULL, 24'd0);
    send_item(ACT_UPDATE, 16'd50, 8'd0);
    // zero user timeout dims on the next tick
    write_reg(CFG_TMO_S, 24'd0);
    send_item(ACT_UPDATE, 16'd0, 8'd0);
    send_item(ACT_WAKE, 16'd0, 8'd0);
    send_item(ACT_UPDATE, 16'hFFFF, 8'd0);
    write_reg(CFG_SPARE, 24'hFFFFFF);
    send_item(ACT_SET, 16'd0, 8'd128);
    send_item(ACT_UPDATE, 16'd50, 8'd0);
    send_item(ACT_UNUSED, 16'd0, 8'd0);

    // Longest timeouts, then drive the counter into saturation
    write_reg(CFG_TMO_S, 24'hFFFF);
    write_reg(CFG_TMO_MS, 24'hFFFFFF);
    write_reg(CFG_LOW, 24'd0);
    write_reg(CFG_FULL, 24'hFF);
    send_item(ACT_WAKE, 16'd0, 8'd0);
    repeat (OVERFLOW_RUN) send_item(ACT_UPDATE, 16'hFFFF, LEVEL_W'($urandom));
    send_item(ACT_WAKE, 16'd0, 8'd0);

    // Random phases; the last runs without any idling
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      run_phase($urandom_range(80, 120));
    end

    // Drain outstanding results, then watch for stray ones
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (12) @(negedge clk);

    $display("Covered %0d updates, %0d wakes, %0d direct sets, %0d unused-code items",
             n_update, n_wake, n_set, n_unused);
    $display("with %0d register writes over %0d random phases; %0d results compared",
             n_cfg, n_phase, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("backlight_auto_dim_fader_tb passed");
    end else begin
      $display("backlight_auto_dim_fader_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Run limit reached with %0d results outstanding", pending);
    $display("backlight_auto_dim_fader_tb failed");
    $finish;
  end

endmodule
